### sv/ecpb_pkg.sv
// shared types and constants of the exact color palette builder
package ecpb_pkg;

  localparam int unsigned COMP_W  = 8;
  localparam int unsigned COLOR_W = 3 * COMP_W;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CNT_W   = 24;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DUMP  = 1'b1;

  typedef struct packed {
    logic [COMP_W-1:0] color_r;
    logic [COMP_W-1:0] color_g;
    logic [COMP_W-1:0] color_b;
    logic              end_of_image;
  } pixel_t;

  typedef struct packed {
    logic              result_kind;
    logic [IDX_W-1:0]  palette_index;
    logic              is_new;
    logic [CNT_W-1:0]  pixel_position;
    logic [COMP_W-1:0] entry_red;
    logic [COMP_W-1:0] entry_green;
    logic [COMP_W-1:0] entry_blue;
    logic [CNT_W-1:0]  pixel_count;
    logic              overflow;
    logic              last;
  } result_t;

  typedef struct packed {
    logic active;
    logic append;
    logic incr;
    logic shift;
  } cell_ctrl_t;

endpackage

### sv/ecpb_cell.sv
// one palette entry cell: color, count, exact match and shift toward cell zero
module ecpb_cell (
  input  logic                         clk_i,
  input  ecpb_pkg::cell_ctrl_t         ctrl_i,
  input  logic [ecpb_pkg::COLOR_W-1:0] pix_color_i,
  input  logic [ecpb_pkg::COLOR_W-1:0] next_color_i,
  input  logic [ecpb_pkg::CNT_W-1:0]   next_count_i,
  output logic [ecpb_pkg::COLOR_W-1:0] color_o,
  output logic [ecpb_pkg::CNT_W-1:0]   count_o,
  output logic                         hit_o
);

  logic [ecpb_pkg::COLOR_W-1:0] color_q, color_d;
  logic [ecpb_pkg::CNT_W-1:0]   count_q, count_d;

  assign hit_o = ctrl_i.active && (color_q == pix_color_i);

  always_comb begin
    color_d = color_q;
    count_d = count_q;
    priority if (ctrl_i.shift) begin
      color_d = next_color_i;
      count_d = next_count_i;
    end else if (ctrl_i.append) begin
      color_d = pix_color_i;
      count_d = ecpb_pkg::CNT_W'(1);
    end else if (ctrl_i.incr && count_q != ecpb_pkg::CNT_MAX) begin
      count_d = count_q + ecpb_pkg::CNT_W'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
    count_q <= count_d;
  end

  assign color_o = color_q;
  assign count_o = count_q;

endmodule

### sv/exact_color_palette_builder_top.sv
// top level of the exact color palette builder: cell chain, control and result register
// Every occupied entry cell compares its color with an accepted pixel
// at once, and the hit or appended entry is updated at the same edge, so pixels flow at one per
// cycle while the result register drains. A pixel marked end_of_image is followed by one dump
// result per occupied entry, one per cycle while the output is not stalled, as the cell chain
// shifts toward cell zero, and input is stalled during the dump. No clearing pass.
module exact_color_palette_builder_top #(
  parameter int unsigned PALETTE_ENTRIES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ecpb_pkg::pixel_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ecpb_pkg::result_t out_data_o
);

  localparam int unsigned IW = ecpb_pkg::IDX_W;
  localparam int unsigned CW = ecpb_pkg::CNT_W;
  localparam logic [IW-1:0] NUM_ENTRIES = IW'(PALETTE_ENTRIES);

  logic [IW-1:0] used_q, used_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          ovf_q, ovf_d;
  logic          dumping_q, dumping_d;
  logic [IW-1:0] dump_idx_q, dump_idx_d;
  logic          out_valid_q, out_valid_d;
  ecpb_pkg::result_t out_q, out_d;

  ecpb_pkg::cell_ctrl_t            ctrl    [PALETTE_ENTRIES];
  logic [ecpb_pkg::COLOR_W-1:0]    colors  [PALETTE_ENTRIES];
  logic [CW-1:0]                   counts  [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0]      hits;

  logic [ecpb_pkg::COLOR_W-1:0] pix_color;
  logic          out_free, accept, dump_fire, dump_last;
  logic          hit_any, room, do_append;
  logic [IW-1:0] hit_idx;

  assign pix_color = {in_data_i.color_r, in_data_i.color_g, in_data_i.color_b};
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = dumping_q || !out_free;
  assign accept    = in_valid_i && !in_stall_o;
  assign dump_fire = dumping_q && out_free;
  assign dump_last = (dump_idx_q + IW'(1)) == used_q;

  assign hit_any   = |hits;
  assign room      = used_q < NUM_ENTRIES;
  assign do_append = accept && !hit_any && room;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      if (hits[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
    logic [ecpb_pkg::COLOR_W-1:0] nxt_color;
    logic [CW-1:0]                nxt_count;

    if (g < PALETTE_ENTRIES - 1) begin : g_mid
      assign nxt_color = colors[g+1];
      assign nxt_count = counts[g+1];
    end else begin : g_end
      assign nxt_color = colors[g];
      assign nxt_count = counts[g];
    end

    assign ctrl[g].active = IW'(g) < used_q;
    assign ctrl[g].append = do_append && (used_q == IW'(g));
    assign ctrl[g].incr   = accept && hits[g];
    assign ctrl[g].shift  = dump_fire;

    ecpb_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[g]),
      .pix_color_i  (pix_color),
      .next_color_i (nxt_color),
      .next_count_i (nxt_count),
      .color_o      (colors[g]),
      .count_o      (counts[g]),
      .hit_o        (hits[g])
    );
  end

  always_comb begin
    used_d      = used_q;
    pos_d       = pos_q;
    ovf_d       = ovf_q;
    dumping_d   = dumping_q;
    dump_idx_d  = dump_idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (accept) begin
      out_valid_d          = 1'b1;
      out_d                = '0;
      out_d.result_kind    = ecpb_pkg::KIND_PIXEL;
      out_d.pixel_position = pos_q;
      out_d.last           = !in_data_i.end_of_image;
      priority if (hit_any) begin
        out_d.palette_index = hit_idx;
      end else if (room) begin
        out_d.palette_index = used_q;
        out_d.is_new        = 1'b1;
        used_d              = used_q + IW'(1);
      end else begin
        out_d.palette_index = NUM_ENTRIES;
        ovf_d               = 1'b1;
      end
      out_d.overflow = ovf_d;
      if (pos_q != ecpb_pkg::CNT_MAX) begin
        pos_d = pos_q + CW'(1);
      end
      if (in_data_i.end_of_image) begin
        dumping_d  = 1'b1;
        dump_idx_d = '0;
      end
    end else if (dump_fire) begin
      out_valid_d         = 1'b1;
      out_d               = '0;
      out_d.result_kind   = ecpb_pkg::KIND_DUMP;
      out_d.palette_index = dump_idx_q;
      out_d.entry_red     = colors[0][23:16];
      out_d.entry_green   = colors[0][15:8];
      out_d.entry_blue    = colors[0][7:0];
      out_d.pixel_count   = counts[0];
      out_d.overflow      = ovf_q;
      out_d.last          = dump_last;
      dump_idx_d          = dump_idx_q + IW'(1);
      if (dump_last) begin
        dumping_d  = 1'b0;
        dump_idx_d = '0;
        used_d     = '0;
        pos_d      = '0;
        ovf_d      = 1'b0;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      dumping_q   <= 1'b0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      dumping_q   <= dumping_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= NUM_ENTRIES)
    else $error("palette fill beyond its size");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dumping_q |-> $onehot0(hits))
    else $error("color matched in more than one entry");

  a_eoi_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.end_of_image) |=> (dumping_q && used_q != '0))
    else $error("end of image did not start a dump");

  a_dump_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dump_fire && dump_last) |=> (used_q == '0 && pos_q == '0 && !ovf_q && !dumping_q))
    else $error("palette not cleared after dump");

endmodule
